[design/tgen_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgen_pkg
// Shared defaults and sequencer state types for the triangle tangent generator.
// ----------------------------------------------------------------------------
package tgen_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF   = 16;

	// main sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MAG,
		ST_MUL,
		ST_FLUSH,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} tgen_state_t;

	// divider sequencer
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIX
	} tdiv_state_t;

endpackage
`default_nettype wire

[design/triangle_tangent_generator_top.sv]
`default_nettype none
// sequence: after the third vertex beat the block forms deltas, magnitudes, the determinant
//   and the numerators, then runs the divider per component unless the triangle is
//   degenerate, and then offers three result beats, one per vertex; a triangle holds
//   the block until its last result beat is taken; the divider yields one bit per cycle
// reset: arst_n clears the sequencer and vertex phase; held vertices are not cleared
// ----------------------------------------------------------------------------
// triangle_tangent_generator_top
// Per-triangle tangent from edge and texture deltas, with one shared
// half-width multiplier and one shared restoring divider.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_top
	import tgen_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
	localparam int unsigned S_DATA_W   = ((5 * COORD_WIDTH + 7) / 8) * 8,
	localparam int unsigned M_DATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [S_DATA_W-1:0]   s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // tangent_x, tangent_y, tangent_z
	output logic [0:0]            m_tuser,   // degenerate
	output logic                  m_tlast
);

	localparam int unsigned CW    = COORD_WIDTH;
	localparam int unsigned H     = (CW + 1) / 2;
	localparam int unsigned PP_W  = 2 * H;
	localparam int unsigned ACC_W = 2 * CW + 2;

	// delta slots
	localparam int unsigned D_DU1 = 0;
	localparam int unsigned D_DV1 = 1;
	localparam int unsigned D_DU2 = 2;
	localparam int unsigned D_DV2 = 3;
	localparam int unsigned D_DP1 = 4;
	localparam int unsigned D_DP2 = 7;
	localparam int unsigned N_D   = 10;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;
	localparam logic [1:0] COMP_LAST = 2'd2;
	localparam logic [1:0] BEAT_LAST = 2'd2;

	tgen_state_t state_q, state_d;

	logic [1:0]          phase_q;
	logic [4:0]          step_q;
	logic [1:0]          comp_q;
	logic [1:0]          beat_q;
	logic                vld_s1;

	logic [CW-1:0]       hp_q [6];
	logic [CW-1:0]       ht_q [4];
	logic [CW-1:0]       cp_q [3];
	logic [CW-1:0]       ct_q [2];
	logic [CW:0]         dl_q [N_D];
	logic [CW-1:0]       mag_q [N_D];
	logic                sgn_q [N_D];

	logic [PP_W-1:0]     pp_s1;
	logic [1:0]          sh_s1;
	logic                neg_s1, first_s1, last_s1;
	logic [1:0]          grp_s1;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    det_q;
	logic [ACC_W-1:0]    num_q [3];
	logic [CW-1:0]       tan_q [3];
	logic                degen_q;

	logic [CW-1:0]       op_a, op_b;
	logic                sa, sb;
	logic [H-1:0]        half_a, half_b;
	logic [ACC_W-1:0]    shifted, base, acc_nxt;

	logic                div_start, div_done;
	logic [CW-1:0]       div_quot;

	logic                s_beat, m_beat;

	assign s_beat = s_tvalid && s_tready;
	assign m_beat = m_tvalid && m_tready;

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FIRST;
			step_q  <= '0;
			comp_q  <= '0;
			beat_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_MUL);
			if (s_beat) begin
				case (phase_q)
					PH_SECOND: phase_q <= PH_THIRD;
					PH_THIRD:  phase_q <= PH_FIRST;
					default:   phase_q <= PH_SECOND;
				endcase
			end
			if (state_q == ST_MUL) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_MAG) begin
				comp_q <= '0;
			end else if (state_q == ST_DIV_WAIT && div_done && comp_q != COMP_LAST) begin
				comp_q <= comp_q + 1'b1;
			end
			if (m_beat) begin
				beat_q <= (beat_q == BEAT_LAST) ? 2'd0 : beat_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && phase_q == PH_THIRD) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: begin
				state_d = ST_MAG;
			end
			ST_MAG: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == '1) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				if (det_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (comp_q == COMP_LAST) ? ST_OUT : ST_DIV_GO;
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && beat_q == BEAT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- operand select for the shared multiplier
	always_comb begin
		case ({step_q[4:3], step_q[2]})
			3'b000: begin op_a = mag_q[D_DU1]; sa = sgn_q[D_DU1];
				op_b = mag_q[D_DV2]; sb = sgn_q[D_DV2]; end
			3'b001: begin op_a = mag_q[D_DV1]; sa = sgn_q[D_DV1];
				op_b = mag_q[D_DU2]; sb = sgn_q[D_DU2]; end
			3'b010: begin op_a = mag_q[D_DP1]; sa = sgn_q[D_DP1];
				op_b = mag_q[D_DV2]; sb = sgn_q[D_DV2]; end
			3'b011: begin op_a = mag_q[D_DP2]; sa = sgn_q[D_DP2];
				op_b = mag_q[D_DV1]; sb = sgn_q[D_DV1]; end
			3'b100: begin op_a = mag_q[D_DP1+1]; sa = sgn_q[D_DP1+1];
				op_b = mag_q[D_DV2]; sb = sgn_q[D_DV2]; end
			3'b101: begin op_a = mag_q[D_DP2+1]; sa = sgn_q[D_DP2+1];
				op_b = mag_q[D_DV1]; sb = sgn_q[D_DV1]; end
			3'b110: begin op_a = mag_q[D_DP1+2]; sa = sgn_q[D_DP1+2];
				op_b = mag_q[D_DV2]; sb = sgn_q[D_DV2]; end
			3'b111: begin op_a = mag_q[D_DP2+2]; sa = sgn_q[D_DP2+2];
				op_b = mag_q[D_DV1]; sb = sgn_q[D_DV1]; end
			default: begin op_a = mag_q[D_DU1]; sa = sgn_q[D_DU1];
				op_b = mag_q[D_DV2]; sb = sgn_q[D_DV2]; end
		endcase
	end

	assign half_a = step_q[1] ? H'(op_a[CW-1:H]) : op_a[H-1:0];
	assign half_b = step_q[0] ? H'(op_b[CW-1:H]) : op_b[H-1:0];

	// ---------------- accumulate stage
	always_comb begin
		case (sh_s1)
			2'd0:    shifted = ACC_W'(pp_s1);
			2'd1:    shifted = ACC_W'(pp_s1) << H;
			2'd2:    shifted = ACC_W'(pp_s1) << (2 * H);
			default: shifted = '0;
		endcase
	end

	assign base    = first_s1 ? '0 : acc_q;
	// second term of each pair is subtracted
	assign acc_nxt = base + (shifted ^ {ACC_W{neg_s1}}) + ACC_W'(neg_s1);

	// ---------------- datapath
	always_ff @(posedge clk) begin
		if (s_beat) begin
			case (phase_q)
				PH_SECOND: begin
					for (int k = 0; k < 3; k++) begin
						hp_q[3+k] <= s_tdata[k*CW +: CW];
					end
					ht_q[2] <= s_tdata[3*CW +: CW];
					ht_q[3] <= s_tdata[4*CW +: CW];
				end
				PH_THIRD: begin
					for (int k = 0; k < 3; k++) begin
						cp_q[k] <= s_tdata[k*CW +: CW];
					end
					ct_q[0] <= s_tdata[3*CW +: CW];
					ct_q[1] <= s_tdata[4*CW +: CW];
				end
				default: begin
					for (int k = 0; k < 3; k++) begin
						hp_q[k] <= s_tdata[k*CW +: CW];
					end
					ht_q[0] <= s_tdata[3*CW +: CW];
					ht_q[1] <= s_tdata[4*CW +: CW];
				end
			endcase
		end

		if (state_q == ST_DELTA) begin
			dl_q[D_DU1] <= {ht_q[2][CW-1], ht_q[2]} - {ht_q[0][CW-1], ht_q[0]};
			dl_q[D_DV1] <= {ht_q[3][CW-1], ht_q[3]} - {ht_q[1][CW-1], ht_q[1]};
			dl_q[D_DU2] <= {ct_q[0][CW-1], ct_q[0]} - {ht_q[0][CW-1], ht_q[0]};
			dl_q[D_DV2] <= {ct_q[1][CW-1], ct_q[1]} - {ht_q[1][CW-1], ht_q[1]};
			for (int k = 0; k < 3; k++) begin
				dl_q[D_DP1+k] <= {hp_q[3+k][CW-1], hp_q[3+k]} - {hp_q[k][CW-1], hp_q[k]};
				dl_q[D_DP2+k] <= {cp_q[k][CW-1], cp_q[k]} - {hp_q[k][CW-1], hp_q[k]};
			end
		end

		if (state_q == ST_MAG) begin
			for (int i = 0; i < N_D; i++) begin
				mag_q[i] <= dl_q[i][CW] ? (~dl_q[i][CW-1:0] + 1'b1) : dl_q[i][CW-1:0];
				sgn_q[i] <= dl_q[i][CW];
			end
		end

		// multiply stage: one half-by-half partial product per cycle
		pp_s1    <= PP_W'(half_a) * PP_W'(half_b);
		sh_s1    <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
		neg_s1   <= sa ^ sb ^ step_q[2];
		first_s1 <= (step_q[2:0] == 3'b000);
		last_s1  <= (step_q[2:0] == 3'b111);
		grp_s1   <= step_q[4:3];

		if (vld_s1) begin
			acc_q <= acc_nxt;
			if (last_s1) begin
				case (grp_s1)
					2'd0:    det_q    <= acc_nxt;
					2'd1:    num_q[0] <= acc_nxt;
					2'd2:    num_q[1] <= acc_nxt;
					default: num_q[2] <= acc_nxt;
				endcase
			end
		end

		if (state_q == ST_DIV_GO) begin
			degen_q <= (det_q == '0);
			if (det_q == '0) begin
				for (int k = 0; k < 3; k++) begin
					tan_q[k] <= '0;
				end
			end
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			tan_q[comp_q] <= div_quot;
		end
	end

	tgen_div #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[comp_q]),
		.den    (det_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign m_tdata    = M_DATA_W'({tan_q[2], tan_q[1], tan_q[0]});
	assign m_tuser[0] = degen_q;
	assign m_tlast    = (beat_q == BEAT_LAST);

`ifndef ASSERT_OFF
	// one triangle in flight: no input beat while results are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result beats pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("not ready for a vertex after the last result beat");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0))
		else $error("degenerate triangle with nonzero tangent");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");
`endif

endmodule
`default_nettype wire

[design/tgen_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgen_div
// Restoring divider, one quotient bit per cycle: num * 2^FRAC_BITS / den,
// truncated toward zero and saturated to the signed coordinate range.
// ----------------------------------------------------------------------------
module tgen_div
	import tgen_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
	localparam int unsigned ACC_W      = 2 * COORD_WIDTH + 2
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  [ACC_W-1:0]        num,
	input  wire  [ACC_W-1:0]        den,
	output logic                    done,
	output logic [COORD_WIDTH-1:0]  quot
);

	localparam int unsigned MAG_W = 2 * COORD_WIDTH + 1;
	localparam int unsigned NSH_W = MAG_W + FRAC_BITS;
	localparam int unsigned DSH_W = MAG_W + COORD_WIDTH;
	localparam int unsigned DW    = (NSH_W > DSH_W) ? NSH_W : DSH_W;
	localparam int unsigned CNT_W = $clog2(COORD_WIDTH + 1);

	localparam logic [COORD_WIDTH-1:0] Q_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] Q_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	tdiv_state_t state_q, state_d;

	logic [DW-1:0]          r_q;
	logic [DW-1:0]          dsh_q;
	logic [COORD_WIDTH:0]   q_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [COORD_WIDTH-1:0] quot_q;

	logic [ACC_W-1:0]       num_abs, den_abs;
	logic [DW:0]            diff;
	logic                   ge;
	logic [COORD_WIDTH-1:0] q_lo, q_neg;
	logic                   sat;

	assign num_abs = num[ACC_W-1] ? (~num + 1'b1) : num;
	assign den_abs = den[ACC_W-1] ? (~den + 1'b1) : den;

	assign diff = {1'b0, r_q} - {1'b0, dsh_q};
	assign ge   = !diff[DW];

	assign q_lo  = q_q[COORD_WIDTH-1:0];
	assign q_neg = ~q_lo + 1'b1;
	// quotient bit at position COORD_WIDTH already means overflow
	assign sat   = q_q[COORD_WIDTH] |
		(neg_q ? (q_lo[COORD_WIDTH-1] & (|q_lo[COORD_WIDTH-2:0])) : q_lo[COORD_WIDTH-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DV_FIX);
			if (state_q == DV_IDLE) begin
				cnt_q <= CNT_W'(COORD_WIDTH);
			end else if (state_q == DV_RUN) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					state_d = DV_RUN;
				end
			end
			DV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DV_FIX;
				end
			end
			DV_FIX: begin
				state_d = DV_IDLE;
			end
			default: begin
				state_d = DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					r_q   <= DW'(num_abs[MAG_W-1:0]) << FRAC_BITS;
					dsh_q <= DW'(den_abs[MAG_W-1:0]) << COORD_WIDTH;
					neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
				end
			end
			DV_RUN: begin
				if (ge) begin
					r_q <= diff[DW-1:0];
				end
				q_q   <= {q_q[COORD_WIDTH-1:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			DV_FIX: begin
				quot_q <= sat ? (neg_q ? Q_MIN : Q_MAX) : (neg_q ? q_neg : q_lo);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire
